// ===== design/hsva_pkg.sv =====
// ----------------------------------------------------------------------------
// hsva_pkg
// Shared types and constants of the hue / saturation / value adjust pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsva_pkg;

    localparam int COMPONENT_BITS_DEF = 16;

    // hue is held in sixths of a turn with 16 fraction bits
    localparam int HUE_FRAC_BITS = 16;
    localparam int Q_BITS        = HUE_FRAC_BITS + 1;
    localparam int DIV_STAGES    = HUE_FRAC_BITS;
    localparam int HUE_BITS      = 22;
    localparam int GAIN_BITS     = 16;
    localparam int ROUND_SHIFT   = 24;

    localparam logic [HUE_BITS-1:0] SECTOR_ONE = 22'd65536;
    localparam logic [HUE_BITS-1:0] FULL_TURN  = 22'd393216;
    localparam logic [15:0]         HUE_ZERO   = 16'd32768;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [1:0]
    {
        REG_HUE_SHIFT  = 2'd0,
        REG_SAT_GAIN   = 2'd1,
        REG_VALUE_GAIN = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    // which component is the maximum
    typedef enum logic [1:0]
    {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } max_sel_t;

    typedef struct packed
    {
        max_sel_t sel;
        logic     neg;
        logic     grey;
    } hue_ctrl_t;

endpackage

`default_nettype wire

// ===== design/hsva_front.sv =====
// ----------------------------------------------------------------------------
// hsva_front
// Max / min search, chroma and value products, first quotient bit of hue.
// ----------------------------------------------------------------------------
`default_nettype none

module hsva_front #(
    parameter int COMPONENT_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [COMPONENT_BITS-1:0]     red,
    input  wire logic [COMPONENT_BITS-1:0]     green,
    input  wire logic [COMPONENT_BITS-1:0]     blue,
    input  wire logic [15:0]                   sat_gain,
    input  wire logic [15:0]                   val_gain,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [COMPONENT_BITS-1:0]          d_out,
    output logic [COMPONENT_BITS-1:0]          rem_out,
    output logic [hsva_pkg::Q_BITS-1:0]        q_out,
    output hsva_pkg::hue_ctrl_t                ctrl_out,
    output logic [COMPONENT_BITS+31:0]         c_out,
    output logic [COMPONENT_BITS+15:0]         v_out
);
    import hsva_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int DW = CB + 16;
    localparam int CW = CB + 32;

    logic [CB-1:0] mx, mn, diff_a, diff_b;
    max_sel_t      sel;

    logic          v1_reg, v2_reg;
    logic          en1, en2;
    logic [CB-1:0] d1_reg, dabs1_reg;
    hue_ctrl_t     ctrl1_reg;
    logic [DW-1:0] ds1_reg;
    logic [DW-1:0] v1p_reg;

    logic [CB-1:0] d2_reg, rem2_reg;
    logic          q2_reg;
    hue_ctrl_t     ctrl2_reg;
    logic [CW-1:0] c2_reg;
    logic [DW-1:0] v2p_reg;

    logic          q_first;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        mx = (red > green) ? red : green;
        if (blue > mx)
            mx = blue;
        mn = (red < green) ? red : green;
        if (blue < mn)
            mn = blue;
        if (mx == red)
        begin
            sel    = MAX_RED;
            diff_a = green;
            diff_b = blue;
        end
        else if (mx == green)
        begin
            sel    = MAX_GREEN;
            diff_a = blue;
            diff_b = red;
        end
        else
        begin
            sel    = MAX_BLUE;
            diff_a = red;
            diff_b = green;
        end
    end

    assign q_first = (dabs1_reg >= d1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            d1_reg         <= mx - mn;
            dabs1_reg      <= (diff_a >= diff_b) ? diff_a - diff_b : diff_b - diff_a;
            ctrl1_reg.sel  <= sel;
            ctrl1_reg.neg  <= (diff_a < diff_b);
            ctrl1_reg.grey <= (mx == mn);
            ds1_reg        <= DW'(mx - mn) * DW'(sat_gain);
            v1p_reg        <= DW'(mx) * DW'(val_gain);
        end
        if (en2 && v1_reg)
        begin
            d2_reg    <= d1_reg;
            q2_reg    <= q_first;
            rem2_reg  <= q_first ? dabs1_reg - d1_reg : dabs1_reg;
            ctrl2_reg <= ctrl1_reg;
            c2_reg    <= CW'(ds1_reg) * CW'(val_gain);
            v2p_reg   <= v1p_reg;
        end
    end

    assign out_valid = v2_reg;
    assign d_out     = d2_reg;
    assign rem_out   = rem2_reg;
    assign q_out     = {{(Q_BITS-1){1'b0}}, q2_reg};
    assign ctrl_out  = ctrl2_reg;
    assign c_out     = c2_reg;
    assign v_out     = v2p_reg;

endmodule

`default_nettype wire

// ===== design/hsva_div_stage.sv =====
// ----------------------------------------------------------------------------
// hsva_div_stage
// One restoring-division step of the hue quotient, payload carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module hsva_div_stage #(
    parameter int COMPONENT_BITS = 16,
    parameter int PAYLOAD_BITS   = 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [COMPONENT_BITS-1:0] d_in,
    input  wire logic [COMPONENT_BITS-1:0] rem_in,
    input  wire logic [hsva_pkg::Q_BITS-1:0] q_in,
    input  wire logic [PAYLOAD_BITS-1:0]   pay_in,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [COMPONENT_BITS-1:0]      d_out,
    output logic [COMPONENT_BITS-1:0]      rem_out,
    output logic [hsva_pkg::Q_BITS-1:0]    q_out,
    output logic [PAYLOAD_BITS-1:0]        pay_out
);
    import hsva_pkg::*;

    localparam int CB = COMPONENT_BITS;

    logic [CB:0]              rem2, rem_sub;
    logic                     qbit;
    logic                     v_reg, en;
    logic [CB-1:0]            d_reg, rem_reg;
    logic [Q_BITS-1:0]        q_reg;
    logic [PAYLOAD_BITS-1:0]  pay_reg;

    assign rem2     = {rem_in, 1'b0};
    assign qbit     = (rem2 >= {1'b0, d_in});
    assign rem_sub  = rem2 - {1'b0, d_in};
    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            d_reg   <= d_in;
            // remainder stays below d, so the top bit drops out
            rem_reg <= qbit ? rem_sub[CB-1:0] : rem2[CB-1:0];
            q_reg   <= {q_in[Q_BITS-2:0], qbit};
            pay_reg <= pay_in;
        end
    end

    assign out_valid = v_reg;
    assign d_out     = d_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
    assign pay_out   = pay_reg;

endmodule

`default_nettype wire

// ===== design/hsva_back.sv =====
// ----------------------------------------------------------------------------
// hsva_back
// Hue rotation and wrap, sector weight, chroma split and RGB rebuild.
// ----------------------------------------------------------------------------
`default_nettype none

module hsva_back #(
    parameter int COMPONENT_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [hsva_pkg::Q_BITS-1:0] q_in,
    input  wire hsva_pkg::hue_ctrl_t         ctrl_in,
    input  wire logic [COMPONENT_BITS+31:0]  c_in,
    input  wire logic [COMPONENT_BITS+15:0]  v_in,
    input  wire logic [15:0]                 hue_shift,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [COMPONENT_BITS-1:0]        red,
    output logic [COMPONENT_BITS-1:0]        green,
    output logic [COMPONENT_BITS-1:0]        blue,
    output logic                             clip
);
    import hsva_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int CW = CB + 32;
    localparam int VW = CB + 16;
    localparam int XW = CB + 16 + Q_BITS;
    localparam int RW = CW - ROUND_SHIFT;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1: hue
    logic signed [HUE_BITS-1:0] qs, h0, shift_s, shift6, h1, h2;
    logic [Q_BITS-1:0]          w;
    logic [2:0]                 sector;

    logic [2:0]        sec1_reg;
    logic [Q_BITS-1:0] w1_reg;
    logic [CW-1:0]     c1_reg;
    logic [VW-1:0]     v1p_reg;

    // stage 2: chroma times weight
    logic [2:0]        sec2_reg;
    logic [XW-1:0]     xa2_reg;
    logic [Q_BITS-1:0] xb2_reg;
    logic [CW-1:0]     c2_reg;
    logic [VW-1:0]     v2p_reg;
    logic [16+Q_BITS-1:0] xb_full;

    // stage 3: per channel drop below value
    logic [CW-1:0] x3, cmx3;
    logic [CW-1:0] drop3 [3];
    logic [CW-1:0] drop3_reg [3];
    logic [VW-1:0] v3p_reg;

    // stage 4: rounding and clamp
    logic [CW-1:0] vfull;
    logic [CW-1:0] val4 [3];
    logic [RW-1:0] rnd4 [3];
    logic [CB-1:0] res4 [3];
    logic [2:0]    clip4;
    logic [CB-1:0] res4_reg [3];
    logic          clip4_reg;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        qs = HUE_BITS'($signed({1'b0, q_in}));
        h0 = '0;
        if (!ctrl_in.grey)
        begin
            case (ctrl_in.sel)
                MAX_RED:   h0 = ctrl_in.neg ? $signed(FULL_TURN) - qs : qs;
                MAX_GREEN: h0 = ctrl_in.neg ? $signed(HUE_BITS'(2 * SECTOR_ONE)) - qs
                                            : $signed(HUE_BITS'(2 * SECTOR_ONE)) + qs;
                MAX_BLUE:  h0 = ctrl_in.neg ? $signed(HUE_BITS'(4 * SECTOR_ONE)) - qs
                                            : $signed(HUE_BITS'(4 * SECTOR_ONE)) + qs;
                default:   h0 = '0;
            endcase
        end
        shift_s = $signed({{(HUE_BITS-16){1'b0}}, hue_shift})
                - $signed({{(HUE_BITS-16){1'b0}}, HUE_ZERO});
        shift6  = (shift_s <<< 2) + (shift_s <<< 1);
        h1      = h0 + shift6;
        h2      = h1;
        if (h1 < 0)
            h2 = h1 + $signed(FULL_TURN);
        else if (h1 >= $signed(FULL_TURN))
            h2 = h1 - $signed(FULL_TURN);
        sector = h2[18:16];
        w      = sector[0] ? Q_BITS'(SECTOR_ONE) - {1'b0, h2[15:0]} : {1'b0, h2[15:0]};
    end

    assign xb_full = {{Q_BITS{1'b0}}, c1_reg[15:0]} * {16'd0, w1_reg};

    always_comb
    begin
        x3   = CW'(xa2_reg) + CW'(xb2_reg);
        cmx3 = c2_reg - x3;
        case (sec2_reg)
            3'd0:
            begin
                drop3[0] = '0;     drop3[1] = cmx3;   drop3[2] = c2_reg;
            end
            3'd1:
            begin
                drop3[0] = cmx3;   drop3[1] = '0;     drop3[2] = c2_reg;
            end
            3'd2:
            begin
                drop3[0] = c2_reg; drop3[1] = '0;     drop3[2] = cmx3;
            end
            3'd3:
            begin
                drop3[0] = c2_reg; drop3[1] = cmx3;   drop3[2] = '0;
            end
            3'd4:
            begin
                drop3[0] = cmx3;   drop3[1] = c2_reg; drop3[2] = '0;
            end
            default:
            begin
                drop3[0] = '0;     drop3[1] = c2_reg; drop3[2] = cmx3;
            end
        endcase
    end

    assign vfull = {{(CW-VW-12){1'b0}}, v3p_reg, 12'd0};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            val4[i] = vfull - drop3_reg[i];
            rnd4[i] = RW'((val4[i] + (CW'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
            if (drop3_reg[i] > vfull)
            begin
                res4[i]  = '0;
                clip4[i] = 1'b1;
            end
            else if (rnd4[i] > RW'({CB{1'b1}}))
            begin
                res4[i]  = '1;
                clip4[i] = 1'b1;
            end
            else
            begin
                res4[i]  = rnd4[i][CB-1:0];
                clip4[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            sec1_reg <= sector;
            w1_reg   <= w;
            c1_reg   <= c_in;
            v1p_reg  <= v_in;
        end
        if (en2 && v1_reg)
        begin
            sec2_reg <= sec1_reg;
            xa2_reg  <= XW'(c1_reg[CW-1:16]) * XW'(w1_reg);
            xb2_reg  <= xb_full[16+Q_BITS-1:16];
            c2_reg   <= c1_reg;
            v2p_reg  <= v1p_reg;
        end
        if (en3 && v2_reg)
        begin
            drop3_reg <= drop3;
            v3p_reg   <= v2p_reg;
        end
        if (en4 && v3_reg)
        begin
            res4_reg  <= res4;
            clip4_reg <= |clip4;
        end
    end

    assign out_valid = v4_reg;
    assign red       = res4_reg[0];
    assign green     = res4_reg[1];
    assign blue      = res4_reg[2];
    assign clip      = clip4_reg;

endmodule

`default_nettype wire

// ===== design/hsv_color_adjust.sv =====
// ----------------------------------------------------------------------------
// hsv_color_adjust
// Hue rotation, saturation and value gain of one RGB pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// input items (red_in, green_in, blue_in) enter on in_valid / in_ready and
// adjusted pixels leave on out_valid / out_ready with a clipped flag.
// registers on the apb port: hue_shift at 0x0, saturation_gain at 0x4,
// value_gain at 0x8; write them only while no pixel is in flight.
// the pipeline has two front stages (min/max, gain products), sixteen
// restoring-division stages for the hue fraction, four back stages. one
// item is taken every clock unless stalled; each stage is elastic, so a
// stalled receiver holds all items in place and bubbles ahead of the
// stall still fill, and in_ready drops only once every stage holds an item.
// reset clears every valid bit and loads hue_shift 32768 (no rotation) and
// both gains 4096 (unity).
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_color_adjust #(
    parameter int COMPONENT_BITS = hsva_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hsva_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [hsva_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [hsva_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [COMPONENT_BITS-1:0]           red_in,
    input  wire logic [COMPONENT_BITS-1:0]           green_in,
    input  wire logic [COMPONENT_BITS-1:0]           blue_in,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [COMPONENT_BITS-1:0]                red_out,
    output logic [COMPONENT_BITS-1:0]                green_out,
    output logic [COMPONENT_BITS-1:0]                blue_out,
    output logic                                     clipped
);
    import hsva_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int CW = CB + 32;
    localparam int VW = CB + 16;
    localparam int PW = $bits(hue_ctrl_t) + CW + VW;

    logic [15:0] hue_reg, sat_reg, val_reg;
    reg_index_t  widx;

    assign widx   = reg_index_t'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= 16'd32768;
            sat_reg <= 16'd4096;
            val_reg <= 16'd4096;
        end
        else if (psel && penable && pwrite)
        begin
            case (widx)
                REG_HUE_SHIFT:  hue_reg <= pwdata[15:0];
                REG_SAT_GAIN:   sat_reg <= pwdata[15:0];
                REG_VALUE_GAIN: val_reg <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_HUE_SHIFT:  prdata = {16'd0, hue_reg};
            REG_SAT_GAIN:   prdata = {16'd0, sat_reg};
            REG_VALUE_GAIN: prdata = {16'd0, val_reg};
            default:        prdata = '0;
        endcase
    end

    // division chain, index 0 is the front output
    logic              dv    [DIV_STAGES+1];
    logic              dr    [DIV_STAGES+1];
    logic [CB-1:0]     dd    [DIV_STAGES+1];
    logic [CB-1:0]     drem  [DIV_STAGES+1];
    logic [Q_BITS-1:0] dq    [DIV_STAGES+1];
    logic [PW-1:0]     dpay  [DIV_STAGES+1];

    hue_ctrl_t     f_ctrl;
    logic [CW-1:0] f_c;
    logic [VW-1:0] f_v;

    hue_ctrl_t     b_ctrl;
    logic [CW-1:0] b_c;
    logic [VW-1:0] b_v;

    hsva_front #(
        .COMPONENT_BITS (CB)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .sat_gain  (sat_reg),
        .val_gain  (val_reg),
        .out_valid (dv[0]),
        .out_ready (dr[0]),
        .d_out     (dd[0]),
        .rem_out   (drem[0]),
        .q_out     (dq[0]),
        .ctrl_out  (f_ctrl),
        .c_out     (f_c),
        .v_out     (f_v)
    );

    assign dpay[0] = {f_ctrl, f_c, f_v};

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        hsva_div_stage #(
            .COMPONENT_BITS (CB),
            .PAYLOAD_BITS   (PW)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv[i]),
            .in_ready  (dr[i]),
            .d_in      (dd[i]),
            .rem_in    (drem[i]),
            .q_in      (dq[i]),
            .pay_in    (dpay[i]),
            .out_valid (dv[i+1]),
            .out_ready (dr[i+1]),
            .d_out     (dd[i+1]),
            .rem_out   (drem[i+1]),
            .q_out     (dq[i+1]),
            .pay_out   (dpay[i+1])
        );
    end

    assign {b_ctrl, b_c, b_v} = dpay[DIV_STAGES];

    hsva_back #(
        .COMPONENT_BITS (CB)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv[DIV_STAGES]),
        .in_ready  (dr[DIV_STAGES]),
        .q_in      (dq[DIV_STAGES]),
        .ctrl_in   (b_ctrl),
        .c_in      (b_c),
        .v_in      (b_v),
        .hue_shift (hue_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red_out),
        .green     (green_out),
        .blue      (blue_out),
        .clip      (clipped)
    );

endmodule

`default_nettype wire
